[design/tilemap_scroll_edge_refresh_assert.svh]
// Assertion macros shared by the tile map scroll block.
`ifndef TILEMAP_SCROLL_EDGE_REFRESH_ASSERT_SVH
`define TILEMAP_SCROLL_EDGE_REFRESH_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TSER_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tser assertion failed");

// Next-cycle implication, checked outside reset.
`define TSER_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tser assertion failed");

`endif

[design/tser_pkg.sv]
// Shared constants, codes and types of the tile map scroll block.
package tser_pkg;

    localparam int MAP_ENTRIES = 6144;
    localparam int MAP_AW      = $clog2(MAP_ENTRIES);
    localparam int IDX_W       = 23;
    localparam int LEN_W       = 11;
    localparam int HGT_W       = 9;
    localparam int CAM_W       = 16;
    localparam int CX_W        = 12;
    localparam int CY_W        = 9;
    localparam int COL_W       = 13;
    localparam int ROW_W       = 11;
    localparam int CNT_W       = 4;
    localparam int SX_W        = 14;
    localparam int SY_W        = 12;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 11;

    localparam int TILE_SHIFT   = 4;
    localparam int VIEW_W_PX    = 10 * 16;
    localparam int VIEW_H_PX    = 9 * 16;
    localparam int COL_TILES    = 11;
    localparam int ROW_TILES    = 13;
    localparam int COL_EDGE_OFS = 22;
    localparam int ROW_EDGE_OFS = 18;
    localparam int ROW_AHEAD    = 9;

    localparam logic [CAM_W-1:0] CAM_X_RESET = 16'd16;
    localparam logic [CAM_W-1:0] CAM_Y_RESET = 16'd464;
    localparam logic [LEN_W-1:0] LEN_RESET   = 11'd10;
    localparam logic [HGT_W-1:0] HGT_RESET   = 9'd9;

    localparam logic [1:0] ACT_MOVE = 2'd0;
    localparam logic [1:0] ACT_SET  = 2'd1;
    localparam logic [1:0] ACT_LOAD = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOVE,
        S_LOADX,
        S_LOADY,
        S_SCAN,
        S_OUT,
        S_FIN
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic axis_y;
        logic fwd;
    } t_cur_ctrl;

    typedef struct packed {
        logic in_range;
        logic empty;
    } t_cur_stat;

endpackage

[design/tser_map.sv]
// Tile map memory: one write port, one registered read port.
module tser_map import tser_pkg::*; (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [MAP_AW-1:0] i_waddr,
    input  logic [7:0]        i_wdata,
    input  logic              i_re,
    input  logic [MAP_AW-1:0] i_raddr,
    output logic [7:0]        o_rdata
);

    logic [7:0] r_mem [MAP_ENTRIES];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/tser_cursor.sv]
// Edge cursor: shared multiply/add unit that walks map index and background position.
module tser_cursor import tser_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cur_ctrl         i_ctrl,
    input  logic [CX_W-1:0]   i_cx,
    input  logic [CY_W-1:0]   i_cy,
    input  logic [LEN_W-1:0]  i_len,
    output t_cur_stat         o_stat,
    output logic [MAP_AW-1:0] o_addr,
    output logic [COL_W-1:0]  o_col,
    output logic [ROW_W-1:0]  o_row
);

    logic signed [IDX_W-1:0] r_idx, n_idx;
    logic [COL_W-1:0]        r_col, n_col;
    logic [ROW_W-1:0]        r_row, n_row;
    logic [CNT_W-1:0]        r_left, n_left;

    logic signed [LEN_W:0]   w_row_base;
    logic signed [LEN_W+1:0] w_len_s;
    logic signed [IDX_W-1:0] w_prod;
    logic signed [IDX_W-1:0] w_col_ofs;
    logic signed [IDX_W-1:0] w_col_base;
    logic [COL_W-1:0]        w_cx2;
    logic [ROW_W-1:0]        w_cy2;

    assign w_len_s = $signed({2'b00, i_len});
    assign w_cx2   = {i_cx, 1'b0};
    assign w_cy2   = {1'b0, i_cy, 1'b0};

    // Row of the first tile: one above the view, or just below it for a downward row.
    always_comb begin
        if (i_ctrl.axis_y && i_ctrl.fwd) begin
            w_row_base = $signed({{(LEN_W+1-CY_W){1'b0}}, i_cy}) + (LEN_W+1)'(ROW_AHEAD);
        end else begin
            w_row_base = $signed({{(LEN_W+1-CY_W){1'b0}}, i_cy}) - (LEN_W+1)'(1);
        end
    end

    assign w_prod    = w_row_base * w_len_s;
    assign w_col_ofs = (!i_ctrl.axis_y && i_ctrl.fwd) ? IDX_W'(COL_TILES) : -IDX_W'(1);
    assign w_col_base = $signed({{(IDX_W-CX_W){1'b0}}, i_cx}) + w_col_ofs;

    always_comb begin
        n_idx  = r_idx;
        n_col  = r_col;
        n_row  = r_row;
        n_left = r_left;
        if (i_ctrl.load) begin
            n_idx = w_prod + w_col_base;
            if (i_ctrl.axis_y) begin
                n_col  = w_cx2 - COL_W'(2);
                n_row  = i_ctrl.fwd ? (w_cy2 + ROW_W'(ROW_EDGE_OFS)) : (w_cy2 - ROW_W'(2));
                n_left = CNT_W'(ROW_TILES);
            end else begin
                n_col  = i_ctrl.fwd ? (w_cx2 + COL_W'(COL_EDGE_OFS)) : (w_cx2 - COL_W'(2));
                n_row  = w_cy2 - ROW_W'(2);
                n_left = CNT_W'(COL_TILES);
            end
        end else if (i_ctrl.step) begin
            // advance one tile along the edge
            if (i_ctrl.axis_y) begin
                n_idx = r_idx + IDX_W'(1);
                n_col = r_col + COL_W'(2);
            end else begin
                n_idx = r_idx + $signed({{(IDX_W-LEN_W){1'b0}}, i_len});
                n_row = r_row + ROW_W'(2);
            end
            n_left = r_left - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else begin
            r_left <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_col <= n_col;
        r_row <= n_row;
    end

    assign o_stat.in_range = !r_idx[IDX_W-1] &&
                             (r_idx[IDX_W-2:0] < (IDX_W-1)'(MAP_ENTRIES));
    assign o_stat.empty    = (r_left == '0);
    assign o_addr          = r_idx[MAP_AW-1:0];
    assign o_col           = r_col;
    assign o_row           = r_row;

endmodule

[design/tilemap_scroll_edge_refresh.sv]
// Tile map scroll block: camera clamp, edge tile refresh sequencer and tile map.
//
// Input channel (i_in_valid / o_in_ready) takes one action per beat: move the
// camera by signed deltas, set it directly, or load one tile map byte. Set and
// load return nothing. A move returns its refresh tiles, then one scroll beat
// with o_kind and o_last high, on o_out_valid / i_out_ready.
// The config channel (i_cfg_valid / o_cfg_ready, always ready) writes level
// length (index 0) and level height (index 1); write it only while idle.
// A move first clamps the camera, then does one cursor load per edge, then reads
// one tile map entry per cycle through the single read port while the output is
// taken each cycle; off-map tiles are skipped and emit nothing. A move emits at
// most 11 + 13 + 1 = 25 beats. The block takes no new input until the scroll
// beat is taken. When the receiver stalls, the beat holds and the sequencer
// waits. Reset places the camera at (16, 464) and the level at 10 by 9 tiles;
// the tile map is not cleared and must be loaded before use.
module tilemap_scroll_edge_refresh import tser_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [1:0]                 i_action,
    input  logic signed [15:0]         i_amount_x,
    input  logic signed [15:0]         i_amount_y,
    input  logic [12:0]                i_map_address,
    input  logic [7:0]                 i_map_data,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_kind,
    output logic [7:0]                 o_tile_code,
    output logic signed [COL_W-1:0]    o_dest_col,
    output logic signed [ROW_W-1:0]    o_dest_row,
    output logic [SX_W-1:0]            o_scroll_x,
    output logic [SY_W-1:0]            o_scroll_y,
    output logic                       o_last
);

    `include "tilemap_scroll_edge_refresh_assert.svh"

    t_state r_state, n_state;

    logic [LEN_W-1:0]       r_len;
    logic [HGT_W-1:0]       r_hgt;
    logic [CAM_W-1:0]       r_cam_x, r_cam_y;
    logic signed [15:0]     r_ax, r_ay;
    logic                   r_dx_pos, r_dy_pos;
    logic [CX_W-1:0]        r_cx;
    logic [CY_W-1:0]        r_cy;
    logic                   r_xchg, r_ychg;
    logic                   r_on_y;
    logic [COL_W-1:0]       r_out_col;
    logic [ROW_W-1:0]       r_out_row;

    logic                   w_in_acc, w_out_acc, w_cfg_acc;
    logic                   w_we, w_rd;
    logic [7:0]             w_rdata;
    t_cur_ctrl              w_ctrl;
    t_cur_stat              w_stat;
    logic [MAP_AW-1:0]      w_raddr;
    logic [COL_W-1:0]       w_col;
    logic [ROW_W-1:0]       w_row;

    logic signed [CAM_W:0]  w_old_x, w_old_y;
    logic signed [CAM_W:0]  w_sum_x, w_sum_y;
    logic signed [CAM_W:0]  w_hi_x, w_hi_y, w_lim_x, w_lim_y;
    logic signed [CAM_W:0]  w_nx, w_ny;
    logic signed [CAM_W:0]  w_otx, w_oty;
    logic                   w_xchg, w_ychg;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_acc   = i_cfg_valid && o_cfg_ready;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_acc   = o_out_valid && i_out_ready;

    // Clamp unit: per axis, add the delta and clamp between zero and the level limit.
    assign w_old_x = $signed({r_cam_x[CAM_W-1], r_cam_x});
    assign w_old_y = $signed({r_cam_y[CAM_W-1], r_cam_y});
    assign w_sum_x = w_old_x + $signed({r_ax[15], r_ax});
    assign w_sum_y = w_old_y + $signed({r_ay[15], r_ay});
    assign w_hi_x  = $signed({2'b00, r_len, 4'b0000}) - (CAM_W+1)'(VIEW_W_PX);
    assign w_hi_y  = $signed({4'b0000, r_hgt, 4'b0000}) - (CAM_W+1)'(VIEW_H_PX);
    assign w_lim_x = w_hi_x[CAM_W] ? '0 : w_hi_x;
    assign w_lim_y = w_hi_y[CAM_W] ? '0 : w_hi_y;

    always_comb begin
        if (w_sum_x > w_lim_x) begin
            w_nx = w_lim_x;
        end else if (w_sum_x[CAM_W]) begin
            w_nx = '0;
        end else begin
            w_nx = w_sum_x;
        end
        if (w_sum_y > w_lim_y) begin
            w_ny = w_lim_y;
        end else if (w_sum_y[CAM_W]) begin
            w_ny = '0;
        end else begin
            w_ny = w_sum_y;
        end
    end

    // Old tile rounds toward zero: bias negatives before the shift.
    assign w_otx  = (w_old_x + (w_old_x[CAM_W] ? (CAM_W+1)'(15) : '0)) >>> TILE_SHIFT;
    assign w_oty  = (w_old_y + (w_old_y[CAM_W] ? (CAM_W+1)'(15) : '0)) >>> TILE_SHIFT;
    assign w_xchg = (w_otx != (w_nx >>> TILE_SHIFT));
    assign w_ychg = (w_oty != (w_ny >>> TILE_SHIFT));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc && (i_action == ACT_MOVE)) begin
                    n_state = S_MOVE;
                end
            end
            S_MOVE: begin
                if (w_xchg) begin
                    n_state = S_LOADX;
                end else if (w_ychg) begin
                    n_state = S_LOADY;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_LOADX, S_LOADY: begin
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (w_stat.empty) begin
                    n_state = (!r_on_y && r_ychg) ? S_LOADY : S_FIN;
                end else if (w_stat.in_range) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_acc) begin
                    n_state = (!w_stat.empty && w_stat.in_range) ? S_OUT : S_SCAN;
                end
            end
            S_FIN: begin
                if (w_out_acc) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_in_ready    = 1'b0;
        o_out_valid   = 1'b0;
        w_rd          = 1'b0;
        w_ctrl.load   = 1'b0;
        w_ctrl.step   = 1'b0;
        w_ctrl.axis_y = r_on_y;
        case (r_state)
            S_IDLE:  o_in_ready = 1'b1;
            S_MOVE:  ;
            S_LOADX: begin
                w_ctrl.load   = 1'b1;
                w_ctrl.axis_y = 1'b0;
            end
            S_LOADY: begin
                w_ctrl.load   = 1'b1;
                w_ctrl.axis_y = 1'b1;
            end
            S_SCAN: begin
                // skip off-map tiles without a beat
                w_ctrl.step = !w_stat.empty;
                w_rd        = !w_stat.empty && w_stat.in_range;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                w_rd        = w_out_acc && !w_stat.empty && w_stat.in_range;
                w_ctrl.step = w_rd;
            end
            S_FIN:   o_out_valid = 1'b1;
            default: ;
        endcase
    end

    assign w_ctrl.fwd = w_ctrl.axis_y ? r_dy_pos : r_dx_pos;
    assign w_we = w_in_acc && (i_action == ACT_LOAD) &&
                  ({1'b0, i_map_address} < 14'(MAP_ENTRIES));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len   <= LEN_RESET;
            r_hgt   <= HGT_RESET;
            r_cam_x <= CAM_X_RESET;
            r_cam_y <= CAM_Y_RESET;
            r_on_y  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cfg_acc) begin
                if (i_cfg_index == CFG_LENGTH) begin
                    r_len <= i_cfg_data;
                end else if (i_cfg_index == CFG_HEIGHT) begin
                    r_hgt <= i_cfg_data[HGT_W-1:0];
                end
            end
            if (w_in_acc && (i_action == ACT_SET)) begin
                r_cam_x <= i_amount_x;
                r_cam_y <= i_amount_y;
            end else if (r_state == S_MOVE) begin
                r_cam_x <= w_nx[CAM_W-1:0];
                r_cam_y <= w_ny[CAM_W-1:0];
            end
            if (r_state == S_LOADX) begin
                r_on_y <= 1'b0;
            end else if (r_state == S_LOADY) begin
                r_on_y <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_ax     <= i_amount_x;
            r_ay     <= i_amount_y;
            r_dx_pos <= !i_amount_x[15] && (i_amount_x != '0);
            r_dy_pos <= !i_amount_y[15] && (i_amount_y != '0);
        end
        if (r_state == S_MOVE) begin
            r_cx   <= w_nx[TILE_SHIFT +: CX_W];
            r_cy   <= w_ny[TILE_SHIFT +: CY_W];
            r_xchg <= w_xchg;
            r_ychg <= w_ychg;
        end
        if (w_rd) begin
            r_out_col <= w_col;
            r_out_row <= w_row;
        end
    end

    tser_cursor u_cursor (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .i_cx    (r_cx),
        .i_cy    (r_cy),
        .i_len   (r_len),
        .o_stat  (w_stat),
        .o_addr  (w_raddr),
        .o_col   (w_col),
        .o_row   (w_row)
    );

    tser_map u_map (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (i_map_address[MAP_AW-1:0]),
        .i_wdata (i_map_data),
        .i_re    (w_rd),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_kind      = (r_state == S_FIN);
    assign o_last      = (r_state == S_FIN);
    assign o_tile_code = (r_state == S_OUT) ? w_rdata : 8'd0;
    assign o_dest_col  = (r_state == S_OUT) ? $signed(r_out_col) : '0;
    assign o_dest_row  = (r_state == S_OUT) ? $signed(r_out_row) : '0;
    assign o_scroll_x  = (r_state == S_FIN) ? r_cam_x[SX_W-1:0] : '0;
    assign o_scroll_y  = (r_state == S_FIN) ? r_cam_y[SY_W-1:0] : '0;

    `TSER_ASSERT_NOW(a_no_in_while_out, i_clk, i_rst_n, o_out_valid, !o_in_ready)
    `TSER_ASSERT_NOW(a_read_on_map, i_clk, i_rst_n, w_rd, w_stat.in_range && !w_stat.empty)
    `TSER_ASSERT_NEXT(a_fin_to_idle, i_clk, i_rst_n, (r_state == S_FIN) && i_out_ready, o_in_ready)
    `TSER_ASSERT_NEXT(a_cam_x_clamped, i_clk, i_rst_n, r_state == S_MOVE, !r_cam_x[CAM_W-1])

endmodule
